[design/i2cmbe_pkg.sv]
// Shared types and constants for the I2C master bit engine.
// No dependencies; used by the front, queue, back and top modules.
`default_nettype none
package i2cmbe_pkg;

  // Operation codes as carried on the input tuser
  localparam logic [2:0] OpTick  = 3'd0;
  localparam logic [2:0] OpStart = 3'd1;
  localparam logic [2:0] OpStop  = 3'd2;
  localparam logic [2:0] OpWrite = 3'd3;
  localparam logic [2:0] OpRead  = 3'd4;
  localparam logic [2:0] OpWait  = 3'd5;
  // Active command value for an idle engine
  localparam logic [2:0] OpIdle  = 3'd0;

  localparam logic [7:0] AckTimeoutReset = 8'd250;
  localparam logic [3:0] BitsPerByte     = 4'd8;

  // Queue between front and back
  localparam int QDepth = 2;
  localparam int QAw    = $clog2(QDepth);

  localparam int InDataW  = 16;
  localparam int OutDataW = 16;

  typedef enum logic [1:0] {
    KindTick,
    KindCmd,
    KindNone
  } kind_e;

  // Classified item handed from front to back
  typedef struct packed {
    kind_e      kind;
    logic [2:0] op;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } item_t;

  // One result item
  typedef struct packed {
    logic       rejected;
    logic       ack_error;
    logic [7:0] rx_byte;
    logic       done_res;
    logic       busy_res;
    logic       sda_drive;
    logic       sda_level;
    logic       scl_level;
  } res_t;

endpackage
`default_nettype wire

[design/i2cmbe_front.sv]
// Front end: unpacks input transfers and classifies them as tick,
// command or ignored code. Depends on i2cmbe_pkg.
`default_nettype none
module i2cmbe_front (
  input  wire logic [2:0]                  op_i,
  input  wire logic [i2cmbe_pkg::InDataW-1:0] data_i,
  output i2cmbe_pkg::item_t                item_o
);

  always_comb begin
    item_o          = '0;
    item_o.op       = op_i;
    item_o.tx_byte  = data_i[7:0];
    item_o.send_ack = data_i[8];
    item_o.sda_in   = data_i[9];
    if (op_i == i2cmbe_pkg::OpTick) begin
      item_o.kind = i2cmbe_pkg::KindTick;
    end else if (op_i <= i2cmbe_pkg::OpWait) begin
      item_o.kind = i2cmbe_pkg::KindCmd;
    end else begin
      item_o.kind = i2cmbe_pkg::KindNone;
    end
  end

endmodule
`default_nettype wire

[design/i2cmbe_queue.sv]
// Short FIFO of classified items between front and back.
// Depends on i2cmbe_pkg.
`default_nettype none
module i2cmbe_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  i2cmbe_pkg::item_t  item_i,
  output logic               ready_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output i2cmbe_pkg::item_t  item_o
);

  i2cmbe_pkg::item_t              mem_q [i2cmbe_pkg::QDepth];
  logic [i2cmbe_pkg::QAw-1:0]     wr_ptr_q, rd_ptr_q;
  logic [i2cmbe_pkg::QAw:0]       count_q;
  logic                           do_push, do_pop;

  assign ready_o = (count_q != (i2cmbe_pkg::QAw+1)'(i2cmbe_pkg::QDepth));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= item_i;
  end

endmodule
`default_nettype wire

[design/i2cmbe_back.sv]
// Back end: bus phase sequencer, timeout register and output register.
// Depends on i2cmbe_pkg.
`default_nettype none
module i2cmbe_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [7:0]    cfg_wdata_i,
  input  wire logic          q_valid_i,
  input  i2cmbe_pkg::item_t  q_item_i,
  output logic               q_pop_o,
  output logic               res_valid_o,
  output i2cmbe_pkg::res_t   res_o,
  input  wire logic          res_ready_i
);

  logic [7:0] timeout_q;
  logic [2:0] cmd_q, cmd_d;
  logic [2:0] phase_q, phase_d;
  logic [3:0] bits_q, bits_d;
  logic [7:0] shift_q, shift_d;
  logic [7:0] wait_q, wait_d;
  logic       ack_q, ack_d;
  logic       scl_q, scl_d, sda_q, sda_d, drv_q, drv_d;
  logic       done, err, rej, fin;
  logic [7:0] rx;
  logic       out_valid_q;
  i2cmbe_pkg::res_t out_q, res_d;

  // take the next item whenever the output slot frees up
  assign q_pop_o     = q_valid_i && (!out_valid_q || res_ready_i);
  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  always_comb begin
    cmd_d = cmd_q; phase_d = phase_q; bits_d = bits_q; shift_d = shift_q;
    wait_d = wait_q; ack_d = ack_q; scl_d = scl_q; sda_d = sda_q; drv_d = drv_q;
    done = 1'b0; err = 1'b0; rej = 1'b0; fin = 1'b0; rx = '0;
    case (q_item_i.kind)
      i2cmbe_pkg::KindTick: begin
        if (cmd_q != i2cmbe_pkg::OpIdle) begin
          case (cmd_q)
            i2cmbe_pkg::OpStart: begin
              if (phase_q == 3'd0) begin
                drv_d = 1'b1; sda_d = 1'b1; scl_d = 1'b1; phase_d = 3'd1;
              end else if (phase_q == 3'd1) begin
                sda_d = 1'b0; phase_d = 3'd2;
              end else begin
                scl_d = 1'b0; done = 1'b1;
              end
            end
            i2cmbe_pkg::OpStop: begin
              if (phase_q > 3'd2) begin
                fin = 1'b1;
              end else if (phase_q == 3'd0) begin
                drv_d = 1'b1; scl_d = 1'b0; sda_d = 1'b0; phase_d = 3'd1;
              end else if (phase_q == 3'd1) begin
                scl_d = 1'b1; phase_d = 3'd2;
              end else begin
                sda_d = 1'b1; done = 1'b1;
              end
            end
            i2cmbe_pkg::OpWrite: begin
              if (phase_q == 3'd0) begin
                drv_d = 1'b1; scl_d = 1'b0; sda_d = shift_q[7]; phase_d = 3'd1;
              end else if (phase_q == 3'd1) begin
                scl_d = 1'b1; phase_d = 3'd2;
              end else begin
                scl_d   = 1'b0;
                shift_d = {shift_q[6:0], 1'b0};
                bits_d  = bits_q + 4'd1;
                if (bits_d >= i2cmbe_pkg::BitsPerByte) done = 1'b1;
                else phase_d = 3'd0;
              end
            end
            i2cmbe_pkg::OpRead: begin
              if (phase_q == 3'd0) begin
                scl_d = 1'b0; drv_d = 1'b0; sda_d = 1'b1; phase_d = 3'd1;
              end else if (phase_q == 3'd1) begin
                scl_d   = 1'b1;
                shift_d = {shift_q[6:0], q_item_i.sda_in};
                bits_d  = bits_q + 4'd1;
                phase_d = (bits_d >= i2cmbe_pkg::BitsPerByte) ? 3'd2 : 3'd0;
              end else if (phase_q == 3'd2) begin
                // ack bit: low for ack, driven high for nack
                scl_d = 1'b0; drv_d = 1'b1; sda_d = !ack_q; phase_d = 3'd3;
              end else if (phase_q == 3'd3) begin
                scl_d = 1'b1; phase_d = 3'd4;
              end else begin
                scl_d = 1'b0; done = 1'b1; rx = shift_q;
              end
            end
            i2cmbe_pkg::OpWait: begin
              if (phase_q == 3'd0) begin
                drv_d = 1'b0; sda_d = 1'b1; scl_d = 1'b1;
                if (!q_item_i.sda_in) phase_d = 3'd1;
                else if (wait_q >= timeout_q) phase_d = 3'd2;
                else wait_d = wait_q + 8'd1;
              end else if (phase_q == 3'd1) begin
                scl_d = 1'b0; done = 1'b1;
              end else if (phase_q == 3'd2) begin
                // timeout: run a stop condition
                drv_d = 1'b1; scl_d = 1'b0; sda_d = 1'b0; phase_d = 3'd3;
              end else if (phase_q == 3'd3) begin
                scl_d = 1'b1; phase_d = 3'd4;
              end else if (phase_q == 3'd4) begin
                sda_d = 1'b1; done = 1'b1; err = 1'b1;
              end else begin
                fin = 1'b1;
              end
            end
            default: fin = 1'b1;
          endcase
        end
      end
      i2cmbe_pkg::KindCmd: begin
        if (cmd_q != i2cmbe_pkg::OpIdle) begin
          rej = 1'b1;
        end else begin
          cmd_d = q_item_i.op; phase_d = '0; bits_d = '0; wait_d = '0;
          if (q_item_i.op == i2cmbe_pkg::OpWrite) shift_d = q_item_i.tx_byte;
          if (q_item_i.op == i2cmbe_pkg::OpRead) begin
            shift_d = '0; ack_d = q_item_i.send_ack;
          end
        end
      end
      default: ;
    endcase
    if (done || fin) begin
      cmd_d = i2cmbe_pkg::OpIdle; phase_d = '0; bits_d = '0;
    end
    res_d.rejected  = rej;
    res_d.ack_error = err;
    res_d.rx_byte   = rx;
    res_d.done_res  = done;
    res_d.busy_res  = (cmd_d != i2cmbe_pkg::OpIdle);
    res_d.sda_drive = drv_d;
    res_d.sda_level = sda_d;
    res_d.scl_level = scl_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q   <= i2cmbe_pkg::AckTimeoutReset;
      cmd_q       <= i2cmbe_pkg::OpIdle;
      phase_q     <= '0;
      bits_q      <= '0;
      shift_q     <= '0;
      wait_q      <= '0;
      ack_q       <= 1'b0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      drv_q       <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) timeout_q <= cfg_wdata_i;
      if (q_pop_o) begin
        cmd_q <= cmd_d; phase_q <= phase_d; bits_q <= bits_d; shift_q <= shift_d;
        wait_q <= wait_d; ack_q <= ack_d; scl_q <= scl_d; sda_q <= sda_d;
        drv_q <= drv_d;
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) out_q <= res_d;
  end

endmodule
`default_nettype wire

[design/i2c_master_bit_engine.sv]
// Top level of the I2C master bit engine: front classifier, item queue
// and back-end phase sequencer. Depends on i2cmbe_pkg and the three submodules.
//
//  channel   direction  payload                         handshake
//  s_axis    in         tuser op, tdata tx/ack/sda      tvalid/tready
//  m_axis    out        tdata pin levels and status     tvalid/tready
//  cfg       in         ack_timeout (8 bit)             write enable only
//
// One result transfer per input transfer, one item per cycle sustained while m_axis_tready is high.
// Each item is registered in the queue, then in the output register.
// The phase sequencer retires one item per cycle; a stalled output holds
// the sequencer while the two-entry queue keeps taking input until full.
// Reset is asynchronous, active low; timeout resets to 250.
`default_nettype none
module i2c_master_bit_engine (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [7:0] tx_byte, [8] send_ack, [9] sda_in, [15:10] zero
  input  wire logic [i2cmbe_pkg::InDataW-1:0] s_axis_tdata,
  // [2:0] operation
  input  wire logic [2:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [0] scl_level, [1] sda_level, [2] sda_drive, [3] busy_res, [4] done_res,
  // [12:5] rx_byte, [13] ack_error, [14] rejected, [15] zero
  output logic [i2cmbe_pkg::OutDataW-1:0] m_axis_tdata,
  input  wire logic        ack_timeout_we_i,
  input  wire logic [7:0]  ack_timeout_wdata_i
);

  i2cmbe_pkg::item_t front_item, q_item;
  i2cmbe_pkg::res_t  res;
  logic              q_valid, q_pop;

  i2cmbe_front u_front (
    .op_i   (s_axis_tuser),
    .data_i (s_axis_tdata),
    .item_o (front_item)
  );

  i2cmbe_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s_axis_tvalid),
    .item_i  (front_item),
    .ready_o (s_axis_tready),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  i2cmbe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (ack_timeout_we_i),
    .cfg_wdata_i (ack_timeout_wdata_i),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .res_valid_o (m_axis_tvalid),
    .res_o       (res),
    .res_ready_i (m_axis_tready)
  );

  // res_t is declared high field first, so it packs lowest-first here
  assign m_axis_tdata = {1'b0, res};

endmodule
`default_nettype wire

[test/i2c_pin_checker.sv]
// Checker for the I2C master bit engine: mirrors the phase sequencer, predicts one
// pin/status result per accepted input transfer and compares the output stream.
// Depends on i2cmbe_pkg for operation codes and the result layout.
module i2c_pin_checker
  import i2cmbe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  // [7:0] tx_byte, [8] send_ack, [9] sda_in
  input  logic [15:0] s_tdata_i,
  // [2:0] operation
  input  logic [2:0]  s_tuser_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  // [0] scl, [1] sda, [2] drive, [3] busy, [4] done, [12:5] rx, [13] ack_error, [14] rejected
  input  logic [15:0] m_tdata_i,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  output int          fail_count_o,
  output int          pins_owed_o
);

  // Mirror of the engine state
  logic [7:0] timeout_q;
  logic [2:0] cmd_q;
  logic [4:0] phase_q;
  logic [3:0] bits_q;
  logic [7:0] shreg_q;
  logic [7:0] waits_q;
  logic       ack_q;
  logic       scl_q;
  logic       sda_q;
  logic       drv_q;

  res_t       want_pins_q[$];
  res_t       want;
  res_t       got;
  int         fails;
  int         n_results;

  // Stop condition, sub-phase p = 0..2; last is set on the final one
  task automatic stop_step(input logic [4:0] p, output logic last);
    last = 1'b0;
    if (p == 5'd0) begin
      drv_q = 1'b1;
      scl_q = 1'b0;
      sda_q = 1'b0;
    end else if (p == 5'd1) begin
      scl_q = 1'b1;
    end else begin
      sda_q = 1'b1;
      last  = 1'b1;
    end
  endtask

  task automatic advance_phase(input logic sda_in, output logic done, output logic err,
                               output logic [7:0] rx);
    logic last;
    logic abort;
    done  = 1'b0;
    err   = 1'b0;
    rx    = 8'd0;
    last  = 1'b0;
    abort = 1'b0;
    case (cmd_q)
      OpStart: begin
        if (phase_q == 5'd0) begin
          drv_q = 1'b1;
          sda_q = 1'b1;
          scl_q = 1'b1;
          phase_q = 5'd1;
        end else if (phase_q == 5'd1) begin
          sda_q = 1'b0;
          phase_q = 5'd2;
        end else begin
          scl_q = 1'b0;
          done  = 1'b1;
        end
      end
      OpStop: begin
        if (phase_q > 5'd2) begin
          abort = 1'b1;
        end else begin
          stop_step(phase_q, last);
          if (last) done = 1'b1;
          else phase_q = phase_q + 5'd1;
        end
      end
      OpWrite: begin
        if (phase_q == 5'd0) begin
          drv_q = 1'b1;
          scl_q = 1'b0;
          sda_q = shreg_q[7];
          phase_q = 5'd1;
        end else if (phase_q == 5'd1) begin
          scl_q = 1'b1;
          phase_q = 5'd2;
        end else begin
          scl_q   = 1'b0;
          shreg_q = {shreg_q[6:0], 1'b0};
          bits_q  = bits_q + 4'd1;
          if (bits_q >= BitsPerByte) done = 1'b1;
          else phase_q = 5'd0;
        end
      end
      OpRead: begin
        if (phase_q == 5'd0) begin
          scl_q = 1'b0;
          drv_q = 1'b0;
          sda_q = 1'b1;
          phase_q = 5'd1;
        end else if (phase_q == 5'd1) begin
          scl_q   = 1'b1;
          shreg_q = {shreg_q[6:0], sda_in};
          bits_q  = bits_q + 4'd1;
          phase_q = (bits_q >= BitsPerByte) ? 5'd2 : 5'd0;
        end else if (phase_q == 5'd2) begin
          // ack slot: low for ack, high for nack
          scl_q = 1'b0;
          drv_q = 1'b1;
          sda_q = ~ack_q;
          phase_q = 5'd3;
        end else if (phase_q == 5'd3) begin
          scl_q = 1'b1;
          phase_q = 5'd4;
        end else begin
          scl_q = 1'b0;
          done  = 1'b1;
          rx    = shreg_q;
        end
      end
      OpWait: begin
        if (phase_q == 5'd0) begin
          drv_q = 1'b0;
          sda_q = 1'b1;
          scl_q = 1'b1;
          if (!sda_in) phase_q = 5'd1;
          else if (waits_q >= timeout_q) phase_q = 5'd2;
          else waits_q = waits_q + 8'd1;
        end else if (phase_q == 5'd1) begin
          scl_q = 1'b0;
          done  = 1'b1;
        end else if (phase_q <= 5'd4) begin
          // timed out: stop condition, error on its last phase
          stop_step(phase_q - 5'd2, last);
          if (last) begin
            done = 1'b1;
            err  = 1'b1;
          end else begin
            phase_q = phase_q + 5'd1;
          end
        end else begin
          abort = 1'b1;
        end
      end
      default: abort = 1'b1;
    endcase
    if (done || abort) begin
      cmd_q   = OpIdle;
      phase_q = 5'd0;
      bits_q  = 4'd0;
    end
  endtask

  task automatic step_engine(input logic [2:0] op, input logic [7:0] tx, input logic ack,
                             input logic sda_in, output res_t r);
    logic       done;
    logic       err;
    logic [7:0] rx;
    done = 1'b0;
    err  = 1'b0;
    rx   = 8'd0;
    r    = '0;
    if (op == OpTick) begin
      if (cmd_q != OpIdle) advance_phase(sda_in, done, err, rx);
    end else if (op <= OpWait) begin
      if (cmd_q != OpIdle) begin
        r.rejected = 1'b1;
      end else begin
        cmd_q   = op;
        phase_q = 5'd0;
        bits_q  = 4'd0;
        waits_q = 8'd0;
        if (op == OpWrite) shreg_q = tx;
        if (op == OpRead) begin
          shreg_q = 8'd0;
          ack_q   = ack;
        end
      end
    end
    r.scl_level = scl_q;
    r.sda_level = sda_q;
    r.sda_drive = drv_q;
    r.busy_res  = (cmd_q != OpIdle);
    r.done_res  = done;
    r.rx_byte   = rx;
    r.ack_error = err;
  endtask

  task automatic note_failure(input string what, input res_t exp_r, input res_t act_r);
    fails++;
    if (fails <= 10) begin
      $display("[%0t] result %0d %s", $realtime, n_results, what);
      $display("  exp scl=%b sda=%b drv=%b busy=%b done=%b rx=%h err=%b rej=%b",
               exp_r.scl_level, exp_r.sda_level, exp_r.sda_drive, exp_r.busy_res,
               exp_r.done_res, exp_r.rx_byte, exp_r.ack_error, exp_r.rejected);
      $display("  got scl=%b sda=%b drv=%b busy=%b done=%b rx=%h err=%b rej=%b",
               act_r.scl_level, act_r.sda_level, act_r.sda_drive, act_r.busy_res,
               act_r.done_res, act_r.rx_byte, act_r.ack_error, act_r.rejected);
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      timeout_q = AckTimeoutReset;
      cmd_q     = OpIdle;
      phase_q   = 5'd0;
      bits_q    = 4'd0;
      shreg_q   = 8'd0;
      waits_q   = 8'd0;
      ack_q     = 1'b0;
      scl_q     = 1'b1;
      sda_q     = 1'b1;
      drv_q     = 1'b1;
      fails     = 0;
      n_results = 0;
      want_pins_q.delete();
      fail_count_o <= 0;
      pins_owed_o  <= 0;
    end else begin
      if (cfg_we_i) timeout_q = cfg_wdata_i;
      if (m_tvalid_i && m_tready_i) begin
        got = m_tdata_i[14:0];
        n_results++;
        if (want_pins_q.size() == 0) begin
          note_failure("arrived with nothing expected", '0, got);
        end else begin
          want = want_pins_q.pop_front();
          if (got !== want) note_failure("mismatch", want, got);
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        step_engine(s_tuser_i, s_tdata_i[7:0], s_tdata_i[8], s_tdata_i[9], want);
        want_pins_q.push_back(want);
      end
      fail_count_o <= fails;
      pins_owed_o  <= want_pins_q.size();
    end
  end

endmodule

[test/testbench.sv]
// Top of the I2C master bit engine regression: clock, reset, stimulus and verdict.
// Depends on i2cmbe_pkg, i2c_master_bit_engine and i2c_pin_checker.
module testbench;
  import i2cmbe_pkg::*;

  // Operation codes with no meaning; the engine leaves its state as it is
  localparam logic [2:0] OpSpareA = 3'd6;
  localparam logic [2:0] OpSpareB = 3'd7;

  // Cycles without any transfer before the run is declared hung. The longest
  // legal quiet stretch is the receiver hold-off plus a drain, well below this.
  localparam int WatchdogLimit = 5000;
  // Receiver hold-off, long enough to fill the two-entry queue and the output reg
  localparam int RxHoldCycles  = 200;
  // Input transfers per random phase
  localparam int PhaseItems    = 50;
  // Cycles let pass after the last result has been checked
  localparam int DrainCycles   = 8;

  typedef enum int {
    IdleNone,
    IdleSender,
    IdleReceiver,
    IdleBoth
  } idle_mode_e;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // [7:0] tx_byte, [8] send_ack, [9] sda_in, [15:10] zero
  logic [2:0]  s_axis_tuser;   // [2:0] operation
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // [0] scl .. [14] rejected, see checker
  logic        ack_timeout_we_i;
  logic [7:0]  ack_timeout_wdata_i;

  int          fail_count;
  int          pins_owed;
  int          quiet_cycles;
  int          items_sent;
  int          tx_idle_pct;
  int          rx_stall_pct;
  int          hold_asked;
  int          hold_served;
  logic [7:0]  timeout_now;

  i2c_master_bit_engine u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .s_axis_tvalid       (s_axis_tvalid),
    .s_axis_tready       (s_axis_tready),
    .s_axis_tdata        (s_axis_tdata),
    .s_axis_tuser        (s_axis_tuser),
    .m_axis_tvalid       (m_axis_tvalid),
    .m_axis_tready       (m_axis_tready),
    .m_axis_tdata        (m_axis_tdata),
    .ack_timeout_we_i    (ack_timeout_we_i),
    .ack_timeout_wdata_i (ack_timeout_wdata_i)
  );

  i2c_pin_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .cfg_we_i     (ack_timeout_we_i),
    .cfg_wdata_i  (ack_timeout_wdata_i),
    .fail_count_o (fail_count),
    .pins_owed_o  (pins_owed)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Watchdog: any transfer on either stream restarts the count
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WatchdogLimit) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: random back-pressure, or a long hold-off when the stimulus asks
  // for one. The hold-off is timed here so the sender keeps pushing meanwhile.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_asked != hold_served) begin
        m_axis_tready <= 1'b0;
        repeat (RxHoldCycles) @(negedge clk_i);
        hold_served++;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  // One input transfer. Entered and left at a falling edge; tvalid stays high
  // on return so back-to-back transfers never toggle it within a step.
  task automatic send(input logic [2:0] op, input logic [7:0] tx, input logic ack,
                      input logic sda);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {6'd0, sda, ack, tx};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    items_sent++;
  endtask

  // Bus tick; the byte and ack fields ride along with random values
  task automatic tick(input logic sda);
    send(OpTick, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), sda);
  endtask

  // Sender pause: nothing in flight, then DrainCycles more for the pipeline
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pins_owed != 0) @(posedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Only called right after settle(), so the engine pipeline is empty
  task automatic write_timeout(input logic [7:0] v);
    ack_timeout_we_i    <= 1'b1;
    ack_timeout_wdata_i <= v;
    @(negedge clk_i);
    ack_timeout_we_i    <= 1'b0;
    timeout_now = v;
  endtask

  // Byte extremes are weighted up so all-ones and all-zeros shifts show often
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) pick_byte = 8'h00;
    else if (r < 4) pick_byte = 8'hFF;
    else pick_byte = 8'($urandom_range(0, 255));
  endfunction

  // One command plus the ticks that carry it through. A share of sequences is
  // cut short or gets a second command mid-way, rejected if the engine is still busy.
  task automatic run_sequence();
    int         roll;
    int         n_ticks;
    int         highs;
    logic [2:0] op;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      // noise: any code, any field
      send(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
           1'($urandom_range(0, 1)));
    end else begin
      op = 3'($urandom_range(OpStart, OpWait));
      send(op, pick_byte(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      case (op)
        OpStart, OpStop: n_ticks = 3;
        OpWrite:         n_ticks = 24;
        OpRead:          n_ticks = 19;
        default:         n_ticks = 3;
      endcase
      if (op == OpWait) begin
        // a run of high samples that may or may not pass the timeout, then a low
        highs = $urandom_range(0, (timeout_now < 8) ? int'(timeout_now) + 2 : 10);
        repeat (highs) tick(1'b1);
        tick(1'b0);
      end
      if (roll < 14) n_ticks = $urandom_range(0, n_ticks);
      for (int i = 0; i < n_ticks; i++) begin
        if (roll >= 14 && roll < 22 && i == n_ticks / 2)
          send(3'($urandom_range(OpStart, OpWait)), pick_byte(), 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)));
        tick(1'($urandom_range(0, 1)));
      end
      repeat ($urandom_range(0, 1)) tick(1'($urandom_range(0, 1)));
    end
  endtask

  task automatic run_phase(input idle_mode_e mode, input logic [7:0] tmo, input bit hold,
                           input bit long_wait);
    int first;
    settle();
    write_timeout(tmo);
    tx_idle_pct  = (mode == IdleSender) ? 54 : (mode == IdleBoth) ? 24 : 0;
    rx_stall_pct = (mode == IdleReceiver) ? 54 : (mode == IdleBoth) ? 24 : 0;
    if (hold) hold_asked++;
    first = items_sent;
    if (long_wait) begin
      // SDA never answers: the wait runs the whole count, then the stop
      send(OpWait, pick_byte(), 1'b0, 1'b1);
      repeat (int'(timeout_now) + 2) tick(1'b1);
      repeat (3) tick(1'($urandom_range(0, 1)));
    end
    while (items_sent - first < PhaseItems) run_sequence();
  endtask

  initial begin
    rst_ni              = 1'b0;
    s_axis_tvalid       = 1'b0;
    s_axis_tdata        = '0;
    s_axis_tuser        = OpTick;
    ack_timeout_we_i    = 1'b0;
    ack_timeout_wdata_i = '0;
    hold_asked          = 0;
    tx_idle_pct         = 0;
    rx_stall_pct        = 0;
    items_sent          = 0;
    timeout_now         = AckTimeoutReset;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: idle ticks and spare codes change nothing
    tick(1'b0);
    tick(1'b1);
    send(OpSpareA, 8'hFF, 1'b1, 1'b1);
    send(OpSpareB, 8'h00, 1'b0, 1'b0);
    // start, with a write arriving while busy
    send(OpStart, 8'h00, 1'b0, 1'b0);
    send(OpWrite, 8'hFF, 1'b1, 1'b1);
    repeat (3) tick(1'b1);
    send(OpStop, 8'h00, 1'b0, 1'b0);
    repeat (3) tick(1'b0);
    // wait-ack answered on the first sample
    send(OpWait, 8'h00, 1'b0, 1'b0);
    tick(1'b0);
    tick(1'b1);
    // zero timeout: the first high sample already runs the stop
    settle();
    write_timeout(8'd0);
    send(OpWait, 8'hFF, 1'b1, 1'b1);
    tick(1'b1);
    repeat (3) tick(1'b1);

    // Random phases over idling modes and timeout settings
    run_phase(IdleNone,     AckTimeoutReset,             1'b0, 1'b0);
    run_phase(IdleSender,   8'd1,                        1'b0, 1'b0);
    run_phase(IdleReceiver, 8'd255,                      1'b1, 1'b1);
    run_phase(IdleBoth,     8'd2,                        1'b0, 1'b0);
    run_phase(IdleNone,     8'($urandom_range(3, 8)),    1'b1, 1'b0);
    run_phase(IdleSender,   8'd0,                        1'b0, 1'b0);
    run_phase(IdleReceiver, 8'($urandom_range(1, 255)),  1'b0, 1'b0);
    run_phase(IdleBoth,     8'd1,                        1'b0, 1'b0);

    settle();
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

[sim.f]
design/i2cmbe_pkg.sv
design/i2cmbe_front.sv
design/i2cmbe_queue.sv
design/i2cmbe_back.sv
design/i2c_master_bit_engine.sv
test/i2c_pin_checker.sv
test/testbench.sv
